### hw/rtl/ptms_pkg.sv
// ptms_pkg: shared codes and constants for the polyline thin/merge stream
// used by polyline_thin_merge_stream; depends on nothing
package ptms_pkg;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_POINT = 2'd1,
      CMD_END   = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam int KIND_WIDTH = 2;
   localparam logic [KIND_WIDTH-1:0] KIND_HEADER = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_POINT  = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_EMPTY  = 2'd2;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 62;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILE_MIN_X  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILE_MIN_Y  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILE_MAX_X  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TILE_MAX_Y  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIMPLIFY_ON = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_SEG_SQR = 3'd5;

   // cos^2 threshold 0.995^2 in Q0.16
   localparam int PROLONG_WIDTH = 16;
   localparam logic [PROLONG_WIDTH-1:0] PROLONG_Q16 = 16'd64882;
   localparam int PROLONG_SHIFT = 16;

   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_SQX    = 15'b000000000000010,
      S_SQY    = 15'b000000000000100,
      S_DOTX   = 15'b000000000001000,
      S_DOTY   = 15'b000000000010000,
      S_DM2    = 15'b000000000100000,
      S_PSD    = 15'b000000001000000,
      S_PQ     = 15'b000000010000000,
      S_CMP    = 15'b000000100000000,
      S_SEGX   = 15'b000001000000000,
      S_SEGY   = 15'b000010000000000,
      S_ENDSQX = 15'b000100000000000,
      S_ENDSQY = 15'b001000000000000,
      S_FINAL  = 15'b010000000000000,
      S_EMIT   = 15'b100000000000000
   } state_type;

endpackage

### hw/rtl/ptms_mul.sv
// ptms_mul: shared shift-add multiplier, one multiplier bit per cycle
// stops early once the remaining multiplier bits are zero; no package use
module ptms_mul #(
   parameter int AW = 152,
   parameter int BW = 68
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [AW-1:0] op_a,
   input  logic [BW-1:0] op_b,
   output logic          done,
   output logic [AW-1:0] product
);

   logic          busy_ff, busy_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [AW-1:0] a_ff, a_in;
   logic [BW-1:0] b_ff, b_in;

   always_comb begin
      done    = busy_ff && (b_ff == '0);
      product = acc_ff;
      busy_in = busy_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in = a_ff << 1;
         b_in = b_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

endmodule

### hw/rtl/polyline_thin_merge_stream.sv
// polyline_thin_merge_stream: tile pretest, duplicate/short-segment thinning, collinear merge
// with simplify_on, an end request measures the last point read when it differs from the tail
// and two points are kept, and a point takes up to 9 multiplies on the shared
// shift-add multiplier, each running through the significant bits of its second operand;
// one request at a time, and a result held by rsp_stall also holds the next request
// synchronous reset clears the sequencer, the feature state, the result slot and the csrs
module polyline_thin_merge_stream #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_cmd,
   input  logic signed [COORD_WIDTH-1:0]         req_x_coord,
   input  logic signed [COORD_WIDTH-1:0]         req_y_coord,
   input  logic signed [COORD_WIDTH-1:0]         req_rect_max_x,
   input  logic signed [COORD_WIDTH-1:0]         req_rect_max_y,
   input  logic                                  req_rect_valid,
   input  logic                                  req_isoline,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ptms_pkg::KIND_WIDTH-1:0]       rsp_kind,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_out_y,
   output logic                                  rsp_last,
   output logic                                  rsp_known_inside,
   output logic                                  rsp_outside,
   input  logic                                  csr_wr_en,
   input  logic [ptms_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ptms_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   import ptms_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int MW  = W + 1;          // differences
   localparam int DW  = 2 * W + 2;      // one product of differences
   localparam int DMW = DW + 1;         // dot magnitude
   localparam int SW  = 2 * W + 3;      // squared length
   localparam int EW  = W + 5;          // rect edges at ten times scale
   localparam int PW  = 4 * W + 24;     // multiplier product
   localparam int BW  = 2 * W + 4;      // multiplier second operand

   function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
      logic [MW-1:0] r;
      r = v[MW-1] ? MW'(-v) : MW'(v);
      return r;
   endfunction

   function automatic logic signed [EW-1:0] x10(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] r;
      r = (v <<< 3) + (v <<< 1);
      return r;
   endfunction

   // configuration
   logic signed [W-1:0] tmin_x_ff, tmin_y_ff, tmax_x_ff, tmax_y_ff;
   logic                simplify_ff;
   logic [CSR_DATA_WIDTH-1:0] min_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tmin_x_ff   <= '0;
         tmin_y_ff   <= '0;
         tmax_x_ff   <= '0;
         tmax_y_ff   <= '0;
         simplify_ff <= 1'b0;
         min_seg_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TILE_MIN_X:  tmin_x_ff <= csr_wdata[W-1:0];
            CSR_TILE_MIN_Y:  tmin_y_ff <= csr_wdata[W-1:0];
            CSR_TILE_MAX_X:  tmax_x_ff <= csr_wdata[W-1:0];
            CSR_TILE_MAX_Y:  tmax_y_ff <= csr_wdata[W-1:0];
            CSR_SIMPLIFY_ON: simplify_ff <= csr_wdata[0];
            CSR_MIN_SEG_SQR: min_seg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer state
   state_type state_ff, state_in, ret_ff, ret_in;
   logic      issued_ff, issued_in;
   logic      rejected_ff, rejected_in;
   logic [1:0] kept_ff, kept_in;
   logic signed [W-1:0]  tail_x_ff, tail_x_in, tail_y_ff, tail_y_in;
   logic signed [W-1:0]  bt_x_ff, bt_x_in, bt_y_ff, bt_y_in;
   logic signed [W-1:0]  rd_x_ff, rd_x_in, rd_y_ff, rd_y_in;
   logic signed [MW-1:0] seg_dx_ff, seg_dx_in, seg_dy_ff, seg_dy_in;
   logic signed [MW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SW-1:0]  seg_sqr_ff, seg_sqr_in, d2_ff, d2_in;
   logic [DW-1:0]  pdx_ff, pdx_in;
   logic           negx_ff, negx_in;
   logic [DMW-1:0] dm_ff, dm_in;
   logic [PW-1:0]  dm2_ff, dm2_in, pq_ff, pq_in;

   // pending result and output slot
   logic [KIND_WIDTH-1:0] pend_kind_ff, pend_kind_in, rsp_kind_ff, rsp_kind_in;
   logic signed [W-1:0]   pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic signed [W-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic pend_last_ff, pend_last_in, pend_ki_ff, pend_ki_in, pend_os_ff, pend_os_in;
   logic rsp_last_ff, rsp_last_in, rsp_ki_ff, rsp_ki_in, rsp_os_ff, rsp_os_in;
   logic rsp_valid_ff, rsp_valid_in;

   // shared multiplier
   logic          mul_start, mul_done, mul_fin, in_mul;
   logic [PW-1:0] mul_a, mul_p;
   logic [BW-1:0] mul_b;

   ptms_mul #(.AW(PW), .BW(BW)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   always_comb begin
      in_mul = (state_ff == S_SQX) || (state_ff == S_SQY) || (state_ff == S_DOTX) ||
               (state_ff == S_DOTY) || (state_ff == S_DM2) || (state_ff == S_PSD) ||
               (state_ff == S_PQ) || (state_ff == S_SEGX) || (state_ff == S_SEGY) ||
               (state_ff == S_ENDSQX) || (state_ff == S_ENDSQY);
      mul_start = in_mul && !issued_ff;
      mul_fin   = issued_ff && mul_done;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQX, S_ENDSQX: begin
            mul_a = PW'(mag(dx_ff));
            mul_b = BW'(mag(dx_ff));
         end
         S_SQY, S_ENDSQY: begin
            mul_a = PW'(mag(dy_ff));
            mul_b = BW'(mag(dy_ff));
         end
         S_DOTX: begin
            mul_a = PW'(mag(seg_dx_ff));
            mul_b = BW'(mag(dx_ff));
         end
         S_DOTY: begin
            mul_a = PW'(mag(seg_dy_ff));
            mul_b = BW'(mag(dy_ff));
         end
         S_DM2: begin
            mul_a = PW'(dm_ff);
            mul_b = BW'(dm_ff);
         end
         S_PSD: begin
            mul_a = PW'(seg_sqr_ff);
            mul_b = BW'(d2_ff);
         end
         S_PQ: begin
            mul_a = pq_ff;
            mul_b = BW'(PROLONG_Q16);
         end
         S_SEGX: begin
            mul_a = PW'(mag(seg_dx_ff));
            mul_b = BW'(mag(seg_dx_ff));
         end
         S_SEGY: begin
            mul_a = PW'(mag(seg_dy_ff));
            mul_b = BW'(mag(seg_dy_ff));
         end
         default: ;
      endcase
   end

   // tile pretest on the start request
   logic signed [EW-1:0] lx0, ly0, lx1, ly1, sxm, wx, sym, wy;
   logic signed [EW-1:0] cx0, cx1, cy0, cy1;
   logic hdr_os, hdr_ki;

   always_comb begin
      lx0 = EW'(req_x_coord);
      ly0 = EW'(req_y_coord);
      lx1 = EW'(req_rect_max_x);
      ly1 = EW'(req_rect_max_y);
      sxm = EW'(tmin_x_ff) + EW'(tmax_x_ff);
      wx  = EW'(tmax_x_ff) - EW'(tmin_x_ff);
      sym = EW'(tmin_y_ff) + EW'(tmax_y_ff);
      wy  = EW'(tmax_y_ff) - EW'(tmin_y_ff);
      if (req_isoline) begin
         // 1.6x about the center, at ten times scale
         cx0 = (sxm <<< 2) + sxm - (wx <<< 3);
         cx1 = (sxm <<< 2) + sxm + (wx <<< 3);
         cy0 = (sym <<< 2) + sym - (wy <<< 3);
         cy1 = (sym <<< 2) + sym + (wy <<< 3);
      end else begin
         cx0 = x10(EW'(tmin_x_ff));
         cx1 = x10(EW'(tmax_x_ff));
         cy0 = x10(EW'(tmin_y_ff));
         cy1 = x10(EW'(tmax_y_ff));
      end
      hdr_os = req_rect_valid &&
               ((cx1 < x10(lx0)) || (cx0 > x10(lx1)) || (cy1 < x10(ly0)) || (cy0 > x10(ly1)));
      hdr_ki = req_rect_valid && !hdr_os && !req_isoline &&
               (tmin_x_ff <= req_x_coord) && (tmax_x_ff >= req_rect_max_x) &&
               (tmin_y_ff <= req_y_coord) && (tmax_y_ff >= req_rect_max_y);
   end

   logic                 push_now, clear_now, slot_free, dot_pos;
   logic signed [W-1:0]  push_x, push_y;
   logic signed [MW-1:0] ndx, ndy;
   logic [SW-1:0]        d2n;
   logic [DMW-1:0]       dot_p, dot_n;
   logic [DW-1:0]        pdy;
   logic                 negy;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      issued_in    = mul_start ? 1'b1 : (mul_fin ? 1'b0 : issued_ff);
      rejected_in  = rejected_ff;
      kept_in      = kept_ff;
      tail_x_in    = tail_x_ff;
      tail_y_in    = tail_y_ff;
      bt_x_in      = bt_x_ff;
      bt_y_in      = bt_y_ff;
      rd_x_in      = rd_x_ff;
      rd_y_in      = rd_y_ff;
      seg_dx_in    = seg_dx_ff;
      seg_dy_in    = seg_dy_ff;
      seg_sqr_in   = seg_sqr_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      d2_in        = d2_ff;
      pdx_in       = pdx_ff;
      negx_in      = negx_ff;
      dm_in        = dm_ff;
      dm2_in       = dm2_ff;
      pq_in        = pq_ff;
      pend_kind_in = pend_kind_ff;
      pend_x_in    = pend_x_ff;
      pend_y_in    = pend_y_ff;
      pend_last_in = pend_last_ff;
      pend_ki_in   = pend_ki_ff;
      pend_os_in   = pend_os_ff;
      push_now     = 1'b0;
      clear_now    = 1'b0;
      push_x       = rd_x_ff;
      push_y       = rd_y_ff;
      ndx = MW'(req_x_coord) - MW'(tail_x_ff);
      ndy = MW'(req_y_coord) - MW'(tail_y_ff);
      d2n = d2_ff + mul_p[SW-1:0];
      pdy  = mul_p[DW-1:0];
      negy = seg_dy_ff[MW-1] ^ dy_ff[MW-1];
      dot_p = (negx_ff ? '0 : DMW'(pdx_ff)) + (negy ? '0 : DMW'(pdy));
      dot_n = (negx_ff ? DMW'(pdx_ff) : '0) + (negy ? DMW'(pdy) : '0);
      dot_pos = dot_p > dot_n;

      slot_free    = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ki_in    = rsp_ki_ff;
      rsp_os_in    = rsp_os_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  CMD_START: begin
                     clear_now    = 1'b1;
                     rejected_in  = hdr_os;
                     pend_kind_in = KIND_HEADER;
                     pend_x_in    = '0;
                     pend_y_in    = '0;
                     pend_last_in = 1'b0;
                     pend_ki_in   = hdr_ki;
                     pend_os_in   = hdr_os;
                     ret_in       = S_IDLE;
                     state_in     = S_EMIT;
                  end
                  CMD_POINT: begin
                     if (!rejected_ff) begin
                        rd_x_in = req_x_coord;
                        rd_y_in = req_y_coord;
                        push_x  = req_x_coord;
                        push_y  = req_y_coord;
                        if (kept_ff == 2'd0) begin
                           push_now = 1'b1;
                        end else if (ndx != '0 || ndy != '0) begin
                           if (simplify_ff) begin
                              dx_in    = ndx;
                              dy_in    = ndy;
                              state_in = S_SQX;
                           end else begin
                              push_now = 1'b1;
                           end
                        end
                     end
                  end
                  CMD_END: begin
                     if (kept_ff == 2'd0) begin
                        pend_kind_in = KIND_EMPTY;
                        pend_x_in    = '0;
                        pend_y_in    = '0;
                        pend_last_in = 1'b1;
                        pend_ki_in   = 1'b0;
                        pend_os_in   = 1'b0;
                        clear_now    = 1'b1;
                        rejected_in  = 1'b0;
                        ret_in       = S_IDLE;
                        state_in     = S_EMIT;
                     end else if (simplify_ff &&
                                  (rd_x_ff != tail_x_ff || rd_y_ff != tail_y_ff)) begin
                        dx_in = MW'(rd_x_ff) - MW'(tail_x_ff);
                        dy_in = MW'(rd_y_ff) - MW'(tail_y_ff);
                        if (kept_ff == 2'd2) begin
                           state_in = S_ENDSQX;
                        end else begin
                           pend_kind_in = KIND_POINT;
                           pend_x_in    = tail_x_ff;
                           pend_y_in    = tail_y_ff;
                           pend_last_in = 1'b0;
                           pend_ki_in   = 1'b0;
                           pend_os_in   = 1'b0;
                           tail_x_in    = rd_x_ff;
                           tail_y_in    = rd_y_ff;
                           ret_in       = S_FINAL;
                           state_in     = S_EMIT;
                        end
                     end else begin
                        state_in = S_FINAL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SQX, S_ENDSQX: begin
            if (mul_fin) begin
               d2_in    = mul_p[SW-1:0];
               state_in = (state_ff == S_SQX) ? S_SQY : S_ENDSQY;
            end
         end
         S_SQY: begin
            if (mul_fin) begin
               d2_in = d2n;
               if (PW'(d2n) < PW'(min_seg_ff)) begin
                  state_in = S_IDLE;
               end else if (kept_ff == 2'd2) begin
                  state_in = S_DOTX;
               end else begin
                  seg_dx_in  = dx_ff;
                  seg_dy_in  = dy_ff;
                  seg_sqr_in = d2n;
                  push_now   = 1'b1;
               end
            end
         end
         S_DOTX: begin
            if (mul_fin) begin
               pdx_in   = mul_p[DW-1:0];
               negx_in  = seg_dx_ff[MW-1] ^ dx_ff[MW-1];
               state_in = S_DOTY;
            end
         end
         S_DOTY: begin
            if (mul_fin) begin
               if (dot_pos) begin
                  dm_in    = dot_p - dot_n;
                  state_in = S_DM2;
               end else begin
                  seg_dx_in  = dx_ff;
                  seg_dy_in  = dy_ff;
                  seg_sqr_in = d2_ff;
                  push_now   = 1'b1;
               end
            end
         end
         S_DM2: begin
            if (mul_fin) begin
               dm2_in   = mul_p;
               state_in = S_PSD;
            end
         end
         S_PSD: begin
            if (mul_fin) begin
               pq_in    = mul_p;
               state_in = S_PQ;
            end
         end
         S_PQ: begin
            if (mul_fin) begin
               pq_in    = mul_p;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            // forward collinear: the new point replaces the tail
            if ((dm2_ff << PROLONG_SHIFT) > pq_ff) begin
               tail_x_in = rd_x_ff;
               tail_y_in = rd_y_ff;
               seg_dx_in = MW'(rd_x_ff) - MW'(bt_x_ff);
               seg_dy_in = MW'(rd_y_ff) - MW'(bt_y_ff);
               state_in  = S_SEGX;
            end else begin
               seg_dx_in  = dx_ff;
               seg_dy_in  = dy_ff;
               seg_sqr_in = d2_ff;
               push_now   = 1'b1;
            end
         end
         S_SEGX: begin
            if (mul_fin) begin
               d2_in    = mul_p[SW-1:0];
               state_in = S_SEGY;
            end
         end
         S_SEGY: begin
            if (mul_fin) begin
               seg_sqr_in = d2n;
               state_in   = S_IDLE;
            end
         end
         S_ENDSQY: begin
            if (mul_fin) begin
               tail_x_in = rd_x_ff;
               tail_y_in = rd_y_ff;
               if (PW'(d2n) < PW'(min_seg_ff)) begin
                  state_in = S_FINAL;
               end else begin
                  pend_kind_in = KIND_POINT;
                  pend_x_in    = tail_x_ff;
                  pend_y_in    = tail_y_ff;
                  pend_last_in = 1'b0;
                  pend_ki_in   = 1'b0;
                  pend_os_in   = 1'b0;
                  ret_in       = S_FINAL;
                  state_in     = S_EMIT;
               end
            end
         end
         S_FINAL: begin
            pend_kind_in = KIND_POINT;
            pend_x_in    = tail_x_ff;
            pend_y_in    = tail_y_ff;
            pend_last_in = 1'b1;
            pend_ki_in   = 1'b0;
            pend_os_in   = 1'b0;
            clear_now    = 1'b1;
            rejected_in  = 1'b0;
            ret_in       = S_IDLE;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_x_in     = pend_x_ff;
               rsp_y_in     = pend_y_ff;
               rsp_last_in  = pend_last_ff;
               rsp_ki_in    = pend_ki_ff;
               rsp_os_in    = pend_os_ff;
               state_in     = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // append a point; the old tail can no longer change and goes out
      if (push_now) begin
         if (kept_ff != 2'd0) begin
            pend_kind_in = KIND_POINT;
            pend_x_in    = tail_x_ff;
            pend_y_in    = tail_y_ff;
            pend_last_in = 1'b0;
            pend_ki_in   = 1'b0;
            pend_os_in   = 1'b0;
            ret_in       = S_IDLE;
            state_in     = S_EMIT;
         end else begin
            state_in = S_IDLE;
         end
         bt_x_in   = tail_x_ff;
         bt_y_in   = tail_y_ff;
         tail_x_in = push_x;
         tail_y_in = push_y;
         kept_in   = (kept_ff == 2'd2) ? 2'd2 : kept_ff + 2'd1;
      end

      if (clear_now) begin
         kept_in    = 2'd0;
         tail_x_in  = '0;
         tail_y_in  = '0;
         bt_x_in    = '0;
         bt_y_in    = '0;
         rd_x_in    = '0;
         rd_y_in    = '0;
         seg_dx_in  = '0;
         seg_dy_in  = '0;
         seg_sqr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         issued_ff    <= 1'b0;
         rejected_ff  <= 1'b0;
         kept_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
         tail_x_ff    <= '0;
         tail_y_ff    <= '0;
         bt_x_ff      <= '0;
         bt_y_ff      <= '0;
         rd_x_ff      <= '0;
         rd_y_ff      <= '0;
         seg_dx_ff    <= '0;
         seg_dy_ff    <= '0;
         seg_sqr_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         issued_ff    <= issued_in;
         rejected_ff  <= rejected_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
         tail_x_ff    <= tail_x_in;
         tail_y_ff    <= tail_y_in;
         bt_x_ff      <= bt_x_in;
         bt_y_ff      <= bt_y_in;
         rd_x_ff      <= rd_x_in;
         rd_y_ff      <= rd_y_in;
         seg_dx_ff    <= seg_dx_in;
         seg_dy_ff    <= seg_dy_in;
         seg_sqr_ff   <= seg_sqr_in;
      end
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      d2_ff        <= d2_in;
      pdx_ff       <= pdx_in;
      negx_ff      <= negx_in;
      dm_ff        <= dm_in;
      dm2_ff       <= dm2_in;
      pq_ff        <= pq_in;
      pend_kind_ff <= pend_kind_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      pend_last_ff <= pend_last_in;
      pend_ki_ff   <= pend_ki_in;
      pend_os_ff   <= pend_os_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ki_ff    <= rsp_ki_in;
      rsp_os_ff    <= rsp_os_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_known_inside = rsp_ki_ff;
   assign rsp_outside      = rsp_os_ff;

endmodule

### verif/tb_polyline_thin_merge_stream.sv
// tb_polyline_thin_merge_stream: self-checking testbench for the polyline thin/merge stream
// predicts each request's results in a scoreboard class; depends on ptms_pkg and the block
module tb_polyline_thin_merge_stream;
   timeunit 1ns;
   timeprecision 1ps;
   import ptms_pkg::*;

   localparam int CW = 32;
   localparam int WATCHDOG_LIMIT = 60000;
   localparam int SETTLE_CYCLES = 2000;

   typedef logic [191:0] wide_t;

   typedef struct {
      cmd_type        cmd;
      logic [CW-1:0]  x;
      logic [CW-1:0]  y;
      logic [CW-1:0]  mx;
      logic [CW-1:0]  my;
      logic           rv;
      logic           iso;
   } request_t;

   typedef struct {
      logic [KIND_WIDTH-1:0] kind;
      logic [CW-1:0]         x;
      logic [CW-1:0]         y;
      logic                  last;
      logic                  ki;
      logic                  os;
   } result_t;

   class thin_merge_scoreboard;
      longint tmin_x, tmin_y, tmax_x, tmax_y;
      bit simplify;
      logic [61:0] min_sqr;
      bit rejected;
      int kept;
      longint tail_x, tail_y, btail_x, btail_y, read_x, read_y, seg_dx, seg_dy;
      wide_t seg_sqr;
      result_t due[$];
      int errors;

      function new();
         tmin_x = 0; tmin_y = 0; tmax_x = 0; tmax_y = 0;
         simplify = 0; min_sqr = 0; errors = 0;
         clear_feature();
      endfunction

      function void clear_feature();
         rejected = 0; kept = 0;
         tail_x = 0; tail_y = 0; btail_x = 0; btail_y = 0; read_x = 0; read_y = 0;
         seg_dx = 0; seg_dy = 0; seg_sqr = '0;
      endfunction

      function longint sext(logic [CW-1:0] v);
         logic signed [CW-1:0] s;
         s = v;
         return longint'(s);
      endfunction

      function wide_t umag(longint v);
         wide_t m;
         m = '0;
         m[63:0] = (v < 0) ? -v : v;
         return m;
      endfunction

      function wide_t sqr_len(longint dx, longint dy);
         wide_t a, b;
         a = umag(dx);
         b = umag(dy);
         return a * a + b * b;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] d);
         case (idx)
            CSR_TILE_MIN_X: tmin_x = sext(d[CW-1:0]);
            CSR_TILE_MIN_Y: tmin_y = sext(d[CW-1:0]);
            CSR_TILE_MAX_X: tmax_x = sext(d[CW-1:0]);
            CSR_TILE_MAX_Y: tmax_y = sext(d[CW-1:0]);
            CSR_SIMPLIFY_ON: simplify = d[0];
            CSR_MIN_SEG_SQR: min_sqr = d[61:0];
            default: ;
         endcase
      endfunction

      function void add(logic [KIND_WIDTH-1:0] k, longint x, longint y, bit l, bit ki, bit os);
         result_t r;
         r.kind = k; r.x = x[CW-1:0]; r.y = y[CW-1:0]; r.last = l; r.ki = ki; r.os = os;
         due = {due, r};
      endfunction

      function void push_point(longint x, longint y);
         if (kept >= 1) add(KIND_POINT, tail_x, tail_y, 0, 0, 0);
         btail_x = tail_x; btail_y = tail_y;
         tail_x = x; tail_y = y;
         if (kept < 2) kept++;
      endfunction

      function void note(request_t r);
         longint lx0, ly0, lx1, ly1, cx0, cx1, cy0, cy1, px, py, dx, dy;
         bit os, ki, pos;
         wide_t d2, p, n, pxm, pym, dm, lhs, rhs, minw;
         minw = '0;
         minw[61:0] = min_sqr;
         case (r.cmd)
            CMD_START: begin
               os = 0; ki = 0;
               clear_feature();
               if (r.rv) begin
                  lx0 = sext(r.x); ly0 = sext(r.y); lx1 = sext(r.mx); ly1 = sext(r.my);
                  if (r.iso) begin
                     // tile grown 1.6x about its center, all at ten times scale
                     cx0 = 5 * (tmin_x + tmax_x) - 8 * (tmax_x - tmin_x);
                     cx1 = 5 * (tmin_x + tmax_x) + 8 * (tmax_x - tmin_x);
                     cy0 = 5 * (tmin_y + tmax_y) - 8 * (tmax_y - tmin_y);
                     cy1 = 5 * (tmin_y + tmax_y) + 8 * (tmax_y - tmin_y);
                  end else begin
                     cx0 = 10 * tmin_x; cx1 = 10 * tmax_x;
                     cy0 = 10 * tmin_y; cy1 = 10 * tmax_y;
                  end
                  if (cx1 < 10 * lx0 || cx0 > 10 * lx1 || cy1 < 10 * ly0 || cy0 > 10 * ly1)
                     os = 1;
                  else if (!r.iso && tmin_x <= lx0 && tmax_x >= lx1 &&
                           tmin_y <= ly0 && tmax_y >= ly1)
                     ki = 1;
               end
               rejected = os;
               add(KIND_HEADER, 0, 0, 0, ki, os);
            end
            CMD_POINT: begin
               if (!rejected) begin
                  px = sext(r.x); py = sext(r.y);
                  read_x = px; read_y = py;
                  if (kept == 0) begin
                     push_point(px, py);
                  end else begin
                     dx = px - tail_x; dy = py - tail_y;
                     if (dx != 0 || dy != 0) begin
                        if (!simplify) begin
                           push_point(px, py);
                        end else begin
                           d2 = sqr_len(dx, dy);
                           if (d2 >= minw) begin
                              pos = 0;
                              if (kept >= 2) begin
                                 p = '0; n = '0;
                                 pxm = umag(seg_dx) * umag(dx);
                                 pym = umag(seg_dy) * umag(dy);
                                 if ((seg_dx < 0) != (dx < 0)) n += pxm; else p += pxm;
                                 if ((seg_dy < 0) != (dy < 0)) n += pym; else p += pym;
                                 if (p > n) begin
                                    dm = p - n;
                                    lhs = dm * dm * wide_t'(65536);
                                    rhs = wide_t'(PROLONG_Q16) * seg_sqr * d2;
                                    pos = lhs > rhs;
                                 end
                              end
                              if (pos) begin
                                 // forward collinear: the tail moves, nothing is emitted
                                 tail_x = px; tail_y = py;
                                 seg_dx = px - btail_x; seg_dy = py - btail_y;
                                 seg_sqr = sqr_len(seg_dx, seg_dy);
                              end else begin
                                 seg_dx = dx; seg_dy = dy; seg_sqr = d2;
                                 push_point(px, py);
                              end
                           end
                        end
                     end
                  end
               end
            end
            CMD_END: begin
               if (kept == 0) begin
                  add(KIND_EMPTY, 0, 0, 1, 0, 0);
               end else begin
                  if (simplify) begin
                     dx = read_x - tail_x; dy = read_y - tail_y;
                     if (dx != 0 || dy != 0) begin
                        // endpoint preservation
                        if (!(kept >= 2 && sqr_len(dx, dy) < minw))
                           add(KIND_POINT, tail_x, tail_y, 0, 0, 0);
                        tail_x = read_x; tail_y = read_y;
                     end
                  end
                  add(KIND_POINT, tail_x, tail_y, 1, 0, 0);
               end
               clear_feature();
            end
            default: ;
         endcase
      endfunction

      function void report(string f, logic [CW-1:0] e, logic [CW-1:0] a);
         $display("%0t mismatch %s expected %0h actual %0h", $time, f, e, a);
         errors++;
      endfunction

      function void check(result_t a);
         result_t e;
         if (due.size() == 0) begin
            $display("%0t unexpected result kind %0d x %0h y %0h", $time, a.kind, a.x, a.y);
            errors++;
            return;
         end
         e = due.pop_front();
         if (a.kind !== e.kind) report("kind", e.kind, a.kind);
         if (a.x !== e.x) report("out_x", e.x, a.x);
         if (a.y !== e.y) report("out_y", e.y, a.y);
         if (a.last !== e.last) report("last", e.last, a.last);
         if (a.ki !== e.ki) report("known_inside", e.ki, a.ki);
         if (a.os !== e.os) report("outside", e.os, a.os);
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, req_rect_valid, req_isoline;
   logic [1:0] req_cmd;
   logic signed [CW-1:0] req_x_coord, req_y_coord, req_rect_max_x, req_rect_max_y;
   logic rsp_valid, rsp_stall, rsp_last, rsp_known_inside, rsp_outside;
   logic [KIND_WIDTH-1:0] rsp_kind;
   logic signed [CW-1:0] rsp_out_x, rsp_out_y;
   logic csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata;

   polyline_thin_merge_stream #(.COORD_WIDTH(CW)) dut (.*);

   thin_merge_scoreboard sb = new();
   int snd_pct = 0, rcv_pct = 0, hold_left = 0, idle_cycles = 0, sent = 0;
   longint tile[4];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_pct);
      end
   end

   always @(posedge clock) begin
      result_t a;
      if (!reset && rsp_valid && !rsp_stall) begin
         a.kind = rsp_kind; a.x = rsp_out_x; a.y = rsp_out_y;
         a.last = rsp_last; a.ki = rsp_known_inside; a.os = rsp_outside;
         sb.check(a);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send(request_t r);
      req_valid <= 1;
      req_cmd <= r.cmd; req_x_coord <= r.x; req_y_coord <= r.y;
      req_rect_max_x <= r.mx; req_rect_max_y <= r.my;
      req_rect_valid <= r.rv; req_isoline <= r.iso;
      do @(posedge clock); while (req_stall);
      sb.note(r);
      sent++;
      if ($urandom_range(99) < snd_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic request_t mk(cmd_type c, longint x, longint y, longint mx = 0,
                                   longint my = 0, bit rv = 0, bit iso = 0);
      request_t r;
      r.cmd = c; r.x = x[CW-1:0]; r.y = y[CW-1:0]; r.mx = mx[CW-1:0]; r.my = my[CW-1:0];
      r.rv = rv; r.iso = iso;
      return r;
   endfunction

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] d);
      csr_wr_en <= 1; csr_index <= idx; csr_wdata <= d;
      @(posedge clock);
      sb.write_reg(idx, d);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   task automatic set_tile(longint x0, longint y0, longint x1, longint y1);
      tile[0] = x0; tile[1] = y0; tile[2] = x1; tile[3] = y1;
      write_csr(CSR_TILE_MIN_X, 62'(x0[CW-1:0]));
      write_csr(CSR_TILE_MIN_Y, 62'(y0[CW-1:0]));
      write_csr(CSR_TILE_MAX_X, 62'(x1[CW-1:0]));
      write_csr(CSR_TILE_MAX_Y, 62'(y1[CW-1:0]));
   endtask

   function automatic longint rnd32();
      return longint'($signed($urandom()));
   endfunction

   task automatic gen_feature();
      longint cx, cy, hx, hy, px, py, stx, sty, sc;
      int n, ch;
      bit rv, iso;
      cx = (tile[0] + tile[2]) / 2 + longint'($signed($urandom_range(0, 2 ** 24))) - 2 ** 23;
      cy = (tile[1] + tile[3]) / 2 + longint'($signed($urandom_range(0, 2 ** 24))) - 2 ** 23;
      if ($urandom_range(19) == 0) begin
         cx = rnd32(); cy = rnd32();
      end
      hx = $urandom_range(0, 2 ** 26); hy = $urandom_range(0, 2 ** 26);
      rv = $urandom_range(9) != 0;
      iso = $urandom_range(2) == 0;
      if ($urandom_range(19) != 0) begin
         if ($urandom_range(9) == 0)
            send(mk(CMD_START, rnd32(), rnd32(), rnd32(), rnd32(), rv, iso));
         else
            send(mk(CMD_START, cx - hx, cy - hy, cx + hx, cy + hy, rv, iso));
      end
      n = $urandom_range(0, 12);
      px = cx; py = cy;
      sc = longint'(1) << $urandom_range(4, 24);
      stx = (longint'($urandom_range(0, 2000)) - 1000) * sc / 1000;
      sty = (longint'($urandom_range(0, 2000)) - 1000) * sc / 1000;
      for (int i = 0; i < n; i++) begin
         ch = $urandom_range(99);
         if (ch < 10) begin
            // exact duplicate of the previous point
         end else if (ch < 20) begin
            px += longint'($urandom_range(0, 8)) - 4; py += longint'($urandom_range(0, 8)) - 4;
         end else if (ch < 65) begin
            px += stx + longint'($urandom_range(0, 16)) - 8;
            py += sty + longint'($urandom_range(0, 16)) - 8;
         end else if (ch < 85) begin
            stx = (longint'($urandom_range(0, 2000)) - 1000) * sc / 1000;
            sty = (longint'($urandom_range(0, 2000)) - 1000) * sc / 1000;
            px += stx; py += sty;
         end else if (ch < 90) begin
            px = rnd32(); py = rnd32();
         end else begin
            px -= stx; py -= sty;
         end
         if ($urandom_range(49) == 0)
            send(mk(CMD_NONE, rnd32(), rnd32(), rnd32(), rnd32(), $urandom_range(1) != 0,
                    $urandom_range(1) != 0));
         send(mk(CMD_POINT, px, py, rnd32(), rnd32(), $urandom_range(1) != 0,
                 $urandom_range(1) != 0));
      end
      if ($urandom_range(19) != 0) send(mk(CMD_END, rnd32(), rnd32()));
   endtask

   task automatic setting(longint x0, longint y0, longint x1, longint y1, bit simp,
                          logic [61:0] msq, int phase, int items);
      int stop;
      set_tile(x0, y0, x1, y1);
      write_csr(CSR_SIMPLIFY_ON, 62'(simp));
      write_csr(CSR_MIN_SEG_SQR, msq);
      case (phase % 4)
         0: begin snd_pct = 0; rcv_pct = 0; end
         1: begin snd_pct = 49; rcv_pct = 0; end
         2: begin snd_pct = 0; rcv_pct = 49; end
         default: begin snd_pct = 25; rcv_pct = 25; end
      endcase
      stop = sent + items;
      while (sent < stop) gen_feature();
      drain();
   endtask

   initial begin
      longint big, cmin, cmax;
      reset = 1;
      req_valid = 0; req_cmd = 0; req_x_coord = 0; req_y_coord = 0;
      req_rect_max_x = 0; req_rect_max_y = 0; req_rect_valid = 0; req_isoline = 0;
      csr_wr_en = 0; csr_index = 0; csr_wdata = 0;
      tile = '{0, 0, 0, 0};
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      big = longint'(1) << 25;
      cmin = -(longint'(1) << 31);
      cmax = (longint'(1) << 31) - 1;

      // directed
      set_tile(-big, -big, big, big);
      write_csr(CSR_SIMPLIFY_ON, 62'(1));
      write_csr(CSR_MIN_SEG_SQR, 62'(1) << 30);
      send(mk(CMD_POINT, 100, 100));                        // points with no start
      send(mk(CMD_END, 0, 0));
      send(mk(CMD_END, 0, 0));                              // empty path
      send(mk(CMD_START, -10, -10, 10, 10, 1, 0));          // wholly inside
      send(mk(CMD_START, -big, -big, big, big, 1, 0));      // touching edges
      send(mk(CMD_START, big, big, 2 * big, 2 * big, 1, 0));  // corner touch
      send(mk(CMD_POINT, 5, 5));                            // point of a corner-touch feature, which is not rejected
      send(mk(CMD_END, 0, 0));
      send(mk(CMD_START, big + 1, 0, 3 * big, 1, 1, 0));    // misses the tile
      send(mk(CMD_START, big + 1, 0, 3 * big, 1, 1, 1));    // grown isoline tile hits
      send(mk(CMD_START, 5 * big, 5 * big, 6 * big, 6 * big, 0, 0));  // invalid rect
      send(mk(CMD_POINT, cmin, cmax));
      send(mk(CMD_POINT, cmin, cmax));                      // duplicate
      send(mk(CMD_POINT, cmax, cmin));
      send(mk(CMD_POINT, 0, 0));
      send(mk(CMD_POINT, 1 << 20, 0));
      send(mk(CMD_POINT, 2 << 20, 1));                      // collinear
      send(mk(CMD_POINT, (2 << 20) + 3, 1));                // too short
      send(mk(CMD_NONE, 7, 7));
      send(mk(CMD_START, 0, 0, 1, 1, 1, 1));                // start while open
      send(mk(CMD_POINT, 0, 0));
      send(mk(CMD_POINT, 1 << 20, 1 << 20));
      send(mk(CMD_POINT, (1 << 20) + 2, (1 << 20) + 2));
      send(mk(CMD_END, 0, 0));                              // endpoint preservation
      drain();

      // random
      setting(-big, -big, big, big, 0, 0, 0, 180);
      setting(-big, -big, big, big, 1, 0, 1, 180);
      hold_left = 3000;
      setting(-big, -big, big, big, 1, 62'(1) << 36, 0, 180);
      setting(cmin, cmin, cmax, cmax, 1, 62'(1) << 40, 2, 160);
      setting(big, big, -big, -big, 1, '1, 3, 120);
      setting(rnd32() >>> 2, rnd32() >>> 2, big * 8, big * 8, 1,
              62'({$urandom, $urandom}) & 62'((62'(1) << 44) - 1), 1, 200);
      setting(-big / 2, -big, big, big / 2, 1, 62'(1) << 20, 2, 200);
      setting(rnd32(), rnd32(), rnd32(), rnd32(), 0, 62'({$urandom, $urandom}), 3, 160);

      if (sb.errors == 0 && sb.due.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
